FILE: design/dtem_pkg.sv
// Shared types and constants for the date/time to epoch-minutes pipeline.
// No dependencies; imported by every dtem_* module and the top level.
`default_nettype none

package dtem_pkg;

   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;
   localparam int MINUTES_W  = 38;

   // Flag positions in req_tuser
   localparam int USER_DATE_SHORT = 0;
   localparam int USER_TIME_SHORT = 1;

   // Year bias keeps the shifted year non-negative; ERA_BIAS = YEAR_BIAS / 400
   localparam logic [18:0] YEAR_BIAS  = 19'd53600;
   localparam logic [10:0] ERA_BIAS   = 11'd134;
   // floor(x / 25) = (x * RECIP_25) >> 24 for x < 2^15
   localparam logic [19:0] RECIP_25   = 20'd671089;
   localparam int          RECIP_SHIFT = 24;
   localparam logic [18:0] YEARS_PER_ERA = 19'd400;
   localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
   localparam logic signed [27:0] DAYS_PER_ERA = 28'sd146097;
   localparam logic signed [27:0] EPOCH_SHIFT  = 28'sd719468;
   localparam logic signed [37:0] MIN_PER_DAY  = 38'sd1440;

   // Input beat: first field (year) in the lowest bits
   typedef struct packed {
      logic [15:0] minute_chars;
      logic [15:0] hour_chars;
      logic [15:0] day_chars;
      logic [15:0] month_chars;
      logic [31:0] year_chars;
   } req_type;

   // After character decode
   typedef struct packed {
      logic signed [18:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic               date_ok;
      logic               time_ok;
      logic [10:0]        tod;
   } parse_type;

   // After era split
   typedef struct packed {
      logic [9:0]  era_idx;   // era + ERA_BIAS
      logic [8:0]  yoe;
      logic [8:0]  doy;
      logic        date_ok;
      logic        time_ok;
      logic [10:0] tod;
   } year_type;

   // Day count ready
   typedef struct packed {
      logic signed [27:0] days;
      logic               time_ok;
      logic [10:0]        tod;
   } days_type;

endpackage

`default_nettype wire

FILE: design/dtem_parse.sv
// Character decode stage: digits, range checks, minute of day.
// Depends on dtem_pkg.
`default_nettype none

module dtem_parse (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  dtem_pkg::req_type              in_data,
   input  logic [dtem_pkg::REQ_USER_W-1:0] in_flags,
   output logic                           out_valid,
   input  logic                           out_ready,
   output dtem_pkg::parse_type            out_data
);
   import dtem_pkg::*;

   function automatic logic signed [8:0] char_val(input logic [7:0] c);
      return signed'({1'b0, c}) - 9'sd48;
   endfunction

   logic signed [18:0] year_in;
   logic signed [12:0] month_in, day_in, hour_in, minute_in;
   logic               date_ok_in, time_ok_in;
   parse_type          data_in;
   logic               valid_ff;
   parse_type          data_ff;

   always_comb begin
      year_in   = 19'(char_val(in_data.year_chars[31:24])) * 19'sd1000
                + 19'(char_val(in_data.year_chars[23:16])) * 19'sd100
                + 19'(char_val(in_data.year_chars[15:8]))  * 19'sd10
                + 19'(char_val(in_data.year_chars[7:0]));
      month_in  = 13'(char_val(in_data.month_chars[15:8])) * 13'sd10
                + 13'(char_val(in_data.month_chars[7:0]));
      day_in    = 13'(char_val(in_data.day_chars[15:8])) * 13'sd10
                + 13'(char_val(in_data.day_chars[7:0]));
      hour_in   = 13'(char_val(in_data.hour_chars[15:8])) * 13'sd10
                + 13'(char_val(in_data.hour_chars[7:0]));
      minute_in = 13'(char_val(in_data.minute_chars[15:8])) * 13'sd10
                + 13'(char_val(in_data.minute_chars[7:0]));

      time_ok_in = !in_flags[USER_TIME_SHORT]
                && hour_in >= 13'sd0 && hour_in <= 13'sd23
                && minute_in >= 13'sd0 && minute_in <= 13'sd59;
      date_ok_in = !in_flags[USER_DATE_SHORT]
                && month_in >= 13'sd1 && month_in <= 13'sd12
                && day_in >= 13'sd1 && day_in <= 13'sd31;

      data_in.year    = year_in;
      data_in.month   = month_in[3:0];
      data_in.day     = day_in[4:0];
      data_in.date_ok = date_ok_in;
      data_in.time_ok = time_ok_in;
      data_in.tod     = 11'(hour_in[4:0]) * 11'd60 + 11'(minute_in[5:0]);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/dtem_year.sv
// Era split: March-based year, day of year, floor(year / 400) by reciprocal.
// Three register stages; depends on dtem_pkg.
`default_nettype none

module dtem_year (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dtem_pkg::parse_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output dtem_pkg::year_type  out_data
);
   import dtem_pkg::*;

   // Days before the first of each month, months counted from March
   function automatic logic [8:0] month_base(input logic [3:0] mp);
      case (mp)
         4'd0:    return 9'd0;
         4'd1:    return 9'd31;
         4'd2:    return 9'd61;
         4'd3:    return 9'd92;
         4'd4:    return 9'd122;
         4'd5:    return 9'd153;
         4'd6:    return 9'd184;
         4'd7:    return 9'd214;
         4'd8:    return 9'd245;
         4'd9:    return 9'd275;
         4'd10:   return 9'd306;
         4'd11:   return 9'd337;
         default: return 9'd0;
      endcase
   endfunction

   // stage A: biased year, day of year
   logic        va_ff;
   logic [18:0] ypa_ff;
   logic [8:0]  doya_ff;
   logic        date_oka_ff, time_oka_ff;
   logic [10:0] toda_ff;
   logic [18:0] ypa_in;
   logic [3:0]  mpa_in;
   logic [8:0]  doya_in;

   // stage B: reciprocal product
   logic        vb_ff;
   logic [33:0] prodb_ff;
   logic [18:0] ypb_ff;
   logic [8:0]  doyb_ff;
   logic        date_okb_ff, time_okb_ff;
   logic [10:0] todb_ff;
   logic [34:0] prodb_in;

   // stage C: era and year of era
   logic        vc_ff;
   year_type    datac_ff;
   logic [9:0]  erac_in;
   logic [18:0] remc_in;

   logic rdy_a, rdy_b, rdy_c;

   assign rdy_c    = !vc_ff || out_ready;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      // January and February belong to the previous year
      ypa_in  = 19'(in_data.year) + YEAR_BIAS
              - ((in_data.month <= 4'd2) ? 19'd1 : 19'd0);
      mpa_in  = (in_data.month > 4'd2) ? in_data.month - 4'd3 : in_data.month + 4'd9;
      doya_in = month_base(mpa_in) + 9'(in_data.day) - 9'd1;

      prodb_in = 35'(ypa_ff[18:4]) * 35'(RECIP_25);

      erac_in = prodb_ff[RECIP_SHIFT +: 10];
      remc_in = ypb_ff - 19'(erac_in) * YEARS_PER_ERA;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            va_ff <= in_valid;
         end
         if (rdy_b) begin
            vb_ff <= va_ff;
         end
         if (rdy_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         ypa_ff      <= ypa_in;
         doya_ff     <= doya_in;
         date_oka_ff <= in_data.date_ok;
         time_oka_ff <= in_data.time_ok;
         toda_ff     <= in_data.tod;
      end
      if (rdy_b) begin
         prodb_ff    <= prodb_in[33:0];
         ypb_ff      <= ypa_ff;
         doyb_ff     <= doya_ff;
         date_okb_ff <= date_oka_ff;
         time_okb_ff <= time_oka_ff;
         todb_ff     <= toda_ff;
      end
      if (rdy_c) begin
         datac_ff.era_idx <= erac_in;
         datac_ff.yoe     <= remc_in[8:0];
         datac_ff.doy     <= doyb_ff;
         datac_ff.date_ok <= date_okb_ff;
         datac_ff.time_ok <= time_okb_ff;
         datac_ff.tod     <= todb_ff;
      end
   end

   assign out_valid = vc_ff;
   assign out_data  = datac_ff;

endmodule

`default_nettype wire

FILE: design/dtem_days.sv
// Day count: day of era, era multiple, epoch shift, malformed dates to zero.
// Two register stages; depends on dtem_pkg.
`default_nettype none

module dtem_days (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dtem_pkg::year_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output dtem_pkg::days_type out_data
);
   import dtem_pkg::*;

   logic               va_ff;
   logic [17:0]        doea_ff;
   logic signed [27:0] eramula_ff;
   logic               date_oka_ff, time_oka_ff;
   logic [10:0]        toda_ff;
   logic [1:0]         centa_in;
   logic [17:0]        doea_in;
   logic signed [10:0] eraa_in;
   logic signed [27:0] eramula_in;

   logic               vb_ff;
   days_type           datab_ff;
   logic signed [27:0] daysb_in;

   logic rdy_a, rdy_b;

   assign rdy_b    = !vb_ff || out_ready;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      // yoe / 100 over 0..399
      if (in_data.yoe >= 9'd300) begin
         centa_in = 2'd3;
      end else if (in_data.yoe >= 9'd200) begin
         centa_in = 2'd2;
      end else if (in_data.yoe >= 9'd100) begin
         centa_in = 2'd1;
      end else begin
         centa_in = 2'd0;
      end
      doea_in = 18'(in_data.yoe) * DAYS_PER_YEAR + 18'(in_data.yoe[8:2])
              - 18'(centa_in) + 18'(in_data.doy);
      eraa_in    = signed'({1'b0, in_data.era_idx}) - signed'(ERA_BIAS);
      eramula_in = 28'(eraa_in) * DAYS_PER_ERA;

      daysb_in = date_oka_ff ? eramula_ff + signed'({10'd0, doea_ff}) - EPOCH_SHIFT
                             : 28'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            va_ff <= in_valid;
         end
         if (rdy_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         doea_ff     <= doea_in;
         eramula_ff  <= eramula_in;
         date_oka_ff <= in_data.date_ok;
         time_oka_ff <= in_data.time_ok;
         toda_ff     <= in_data.tod;
      end
      if (rdy_b) begin
         datab_ff.days    <= daysb_in;
         datab_ff.time_ok <= time_oka_ff;
         datab_ff.tod     <= toda_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = datab_ff;

endmodule

`default_nettype wire

FILE: design/date_time_to_epoch_minutes.sv
// Converts an ASCII date (YYYY-MM-DD) and time (HH:MM), given as raw
// character bytes, into minutes since 1970-01-01 00:00 on the proleptic
// Gregorian calendar. Each character is taken as byte - '0' without any digit
// check. A short time string, an hour outside 0..23 or a minute outside 0..59
// gives abs_minutes = -1 with time_valid low. A short date string, a month
// outside 1..12 or a day outside 1..31 counts as day zero, leaving only the
// minutes within the day. A day past the end of its month rolls into the next.
// Rate: one beat per cycle; register stages from req accept to rsp valid
// (decode, year bias, reciprocal multiply for /400, era remainder, day of era
// and era multiply, epoch shift, minutes multiply). Every stage has its own
// valid bit and holds under back-pressure, so bubbles fill in while rsp is
// stalled and nothing is dropped or repeated. No reset sweep; ready follows
// reset release directly.
`default_nettype none

module date_time_to_epoch_minutes (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // year_chars[31:0], month_chars[47:32], day_chars[63:48],
   // hour_chars[79:64], minute_chars[95:80]
   input  logic [dtem_pkg::REQ_DATA_W-1:0] req_tdata,
   // date_short[0], time_short[1]
   input  logic [dtem_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // abs_minutes[37:0] (signed), zero fill [39:38]
   output logic [dtem_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // time_valid[0]
   output logic [dtem_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import dtem_pkg::*;

   logic      parse_valid, parse_ready;
   parse_type parse_data;
   logic      year_valid, year_ready;
   year_type  year_data;
   logic      days_valid, days_ready;
   days_type  days_data;

   // output register
   logic                      out_rdy;
   logic                      rsp_valid_ff;
   logic signed [MINUTES_W-1:0] minutes_ff;
   logic                      time_ok_ff;
   logic signed [MINUTES_W-1:0] minutes_in;

   dtem_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_type'(req_tdata)),
      .in_flags  (req_tuser),
      .out_valid (parse_valid),
      .out_ready (parse_ready),
      .out_data  (parse_data)
   );

   dtem_year u_year (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (parse_valid),
      .in_ready  (parse_ready),
      .in_data   (parse_data),
      .out_valid (year_valid),
      .out_ready (year_ready),
      .out_data  (year_data)
   );

   dtem_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (year_valid),
      .in_ready  (year_ready),
      .in_data   (year_data),
      .out_valid (days_valid),
      .out_ready (days_ready),
      .out_data  (days_data)
   );

   assign out_rdy    = !rsp_valid_ff || rsp_tready;
   assign days_ready = out_rdy;

   // invalid time overrides everything with -1
   always_comb begin
      if (days_data.time_ok) begin
         minutes_in = 38'(days_data.days) * MIN_PER_DAY + signed'({27'd0, days_data.tod});
      end else begin
         minutes_in = -38'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= days_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         minutes_ff <= minutes_in;
         time_ok_ff <= days_data.time_ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - MINUTES_W){1'b0}}, minutes_ff};
   assign rsp_tuser  = time_ok_ff;

   // an invalid time always reports -1
   a_invalid_is_minus_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[MINUTES_W-1:0] == {MINUTES_W{1'b1}})
      else $error("invalid time did not give -1");

   // with the output register empty every stage moves, so input is open
   a_empty_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline blocked with empty output");

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for date_time_to_epoch_minutes: directed and random timestamps.
// Depends on dtem_pkg and the date_time_to_epoch_minutes RTL only.

module tb_top;

   // Characters are offset from ASCII zero, with no digit check
   localparam int CHAR_ZERO = 48;

   localparam longint DAYS_IN_ERA   = 146097;
   localparam longint DAYS_TO_EPOCH = 719468;
   localparam longint MINS_IN_DAY   = 1440;

   localparam int RANDOM_BEATS = 1526;
   localparam int CALM_BEATS   = 200;    // tail of the run with no idling
   localparam int HOLD_CYCLES  = 80;     // long rsp_tready hold-off
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE_PAD   = 20;     // covers the pipeline and then some

   // One timestamp, plus the expected result where it is typed in by hand
   typedef struct {
      logic [31:0] year_chars;
      logic [15:0] month_chars;
      logic [15:0] day_chars;
      logic [15:0] hour_chars;
      logic [15:0] minute_chars;
      logic        date_short;
      logic        time_short;
      bit          known;
      logic [37:0] want_minutes;
      logic        want_valid;
   } stamp_type;

   typedef struct {
      logic [37:0] minutes;
      logic        valid;
      int          beat;
   } result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [dtem_pkg::REQ_DATA_W-1:0] req_tdata;   // year, month, day, hour, minute chars
   logic [dtem_pkg::REQ_USER_W-1:0] req_tuser;   // date_short[0], time_short[1]
   logic rsp_tvalid;
   logic rsp_tready;
   logic [dtem_pkg::RSP_DATA_W-1:0] rsp_tdata;   // abs_minutes[37:0], zero fill [39:38]
   logic [dtem_pkg::RSP_USER_W-1:0] rsp_tuser;   // time_valid[0]

   result_type  pending_epochs[$];
   stamp_type   directed_stamps[$];

   int  error_count   = 0;
   int  beats_sent    = 0;
   int  beats_checked = 0;
   bit  calm_tail     = 0;    // both sides stop idling
   bit  hold_request  = 0;    // asks the receiver for one long hold-off
   int  drain_cycles;
   stamp_type   stamp;
   result_type  want;

   date_time_to_epoch_minutes uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic longint char_val(input logic [7:0] c);
      longint v;
      v = c;
      return v - CHAR_ZERO;
   endfunction

   function automatic longint pair_val(input logic [15:0] w);
      return char_val(w[15:8]) * 10 + char_val(w[7:0]);
   endfunction

   // Expected minutes since the epoch for one timestamp
   function automatic result_type epoch_minutes_of(input stamp_type s);
      result_type e;
      longint hr, mn, yr, mo, dy, era, yoe, doy, doe, days, total;
      e.beat = 0;
      hr = pair_val(s.hour_chars);
      mn = pair_val(s.minute_chars);
      if (s.time_short || hr < 0 || hr > 23 || mn < 0 || mn > 59) begin
         e.minutes = '1;
         e.valid   = 1'b0;
         return e;
      end
      days = 0;
      if (!s.date_short) begin
         yr = char_val(s.year_chars[31:24]) * 1000 + char_val(s.year_chars[23:16]) * 100
            + char_val(s.year_chars[15:8]) * 10 + char_val(s.year_chars[7:0]);
         mo = pair_val(s.month_chars);
         dy = pair_val(s.day_chars);
         if (mo >= 1 && mo <= 12 && dy >= 1 && dy <= 31) begin
            // year runs March to February; floor division for negative years
            if (mo <= 2) yr = yr - 1;
            era  = (yr >= 0 ? yr : yr - 399) / 400;
            yoe  = yr - era * 400;
            doy  = (153 * (mo + (mo > 2 ? -3 : 9)) + 2) / 5 + dy - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * DAYS_IN_ERA + doe - DAYS_TO_EPOCH;
         end
      end
      total     = days * MINS_IN_DAY + hr * 60 + mn;
      e.minutes = total[37:0];
      e.valid   = 1'b1;
      return e;
   endfunction

   function automatic logic [15:0] two_digits(input int v);
      logic [15:0] w;
      w[15:8] = 8'(CHAR_ZERO + v / 10);
      w[7:0]  = 8'(CHAR_ZERO + v % 10);
      return w;
   endfunction

   function automatic logic [31:0] four_digits(input int v);
      return {two_digits(v / 100), two_digits(v % 100)};
   endfunction

   function automatic stamp_type make_stamp(input logic [31:0] yc, input logic [15:0] mc,
                                            input logic [15:0] dc, input int ds,
                                            input logic [15:0] hc, input logic [15:0] nc,
                                            input int ts, input int known,
                                            input logic [37:0] wm, input int wv);
      stamp_type r;
      r.year_chars   = yc;
      r.month_chars  = mc;
      r.day_chars    = dc;
      r.date_short   = 1'(ds);
      r.hour_chars   = hc;
      r.minute_chars = nc;
      r.time_short   = 1'(ts);
      r.known        = (known != 0);
      r.want_minutes = wm;
      r.want_valid   = 1'(wv);
      return r;
   endfunction

   // Directed table; rows marked known carry a hand-typed answer
   task automatic load_directed();
      // the epoch itself, and the last minute of its first day
      directed_stamps.push_back(make_stamp("1970", "01", "01", 0, "00", "00", 0, 1, 38'd0, 1));
      directed_stamps.push_back(make_stamp("1970", "01", "01", 0, "23", "59", 0, 1, 38'd1439, 1));
      // one minute before the epoch reads as -1 but stays valid
      directed_stamps.push_back(make_stamp("1969", "12", "31", 0, "23", "59", 0, 1, '1, 1));
      // invalid time: short string, hour 24, minute 60, non-digit hour
      directed_stamps.push_back(make_stamp("2024", "06", "15", 0, "12", "00", 1, 1, '1, 0));
      directed_stamps.push_back(make_stamp("2024", "06", "15", 0, "24", "00", 0, 1, '1, 0));
      directed_stamps.push_back(make_stamp("2024", "06", "15", 0, "00", "60", 0, 1, '1, 0));
      directed_stamps.push_back(make_stamp("2024", "06", "15", 0, "/0", "00", 0, 1, '1, 0));
      // all-zero and all-ones beats both fail the time check
      directed_stamps.push_back(make_stamp('0, '0, '0, 0, '0, '0, 0, 1, '1, 0));
      directed_stamps.push_back(make_stamp('1, '1, '1, 1, '1, '1, 1, 1, '1, 0));
      // malformed date leaves only the minutes of the day
      directed_stamps.push_back(make_stamp("2024", "06", "15", 1, "12", "34", 0, 1, 38'd754, 1));
      directed_stamps.push_back(make_stamp("2024", "00", "15", 0, "12", "34", 0, 1, 38'd754, 1));
      directed_stamps.push_back(make_stamp("2024", "13", "15", 0, "12", "34", 0, 1, 38'd754, 1));
      directed_stamps.push_back(make_stamp("2024", "06", "00", 0, "12", "34", 0, 1, 38'd754, 1));
      directed_stamps.push_back(make_stamp("2024", "06", "32", 0, "12", "34", 0, 1, 38'd754, 1));
      // leap days, impossible day of month, year zero, far future
      directed_stamps.push_back(make_stamp("2000", "02", "29", 0, "12", "00", 0, 0, '0, 0));
      directed_stamps.push_back(make_stamp("1600", "02", "29", 0, "06", "30", 0, 0, '0, 0));
      directed_stamps.push_back(make_stamp("2023", "04", "31", 0, "08", "15", 0, 0, '0, 0));
      directed_stamps.push_back(make_stamp("0000", "01", "01", 0, "00", "00", 0, 0, '0, 0));
      directed_stamps.push_back(make_stamp("0000", "03", "01", 0, "00", "00", 0, 0, '0, 0));
      directed_stamps.push_back(make_stamp("9999", "12", "31", 0, "23", "59", 0, 0, '0, 0));
      // year bytes at both extremes give the most negative and most positive years
      directed_stamps.push_back(make_stamp(32'h0000_0000, "01", "01", 0, "00", "00", 0,
                                           0, '0, 0));
      directed_stamps.push_back(make_stamp(32'hFFFF_FFFF, "12", "31", 0, "23", "59", 0,
                                           0, '0, 0));
      // non-digits: first row lands in range, second has month and day out of range
      directed_stamps.push_back(make_stamp("19:;", "0<", "1?", 0, "1;", "4;", 0, 0, '0, 0));
      directed_stamps.push_back(make_stamp("2024", ":0", "3:", 0, "10", "10", 0, 0, '0, 0));
   endtask

   // Mostly well-formed stamps with random content, the rest noise of several kinds
   function automatic stamp_type random_stamp();
      stamp_type r;
      int i;
      r = make_stamp(four_digits($urandom_range(0, 9999)), two_digits($urandom_range(1, 12)),
                     two_digits($urandom_range(1, 31)), 0, two_digits($urandom_range(0, 23)),
                     two_digits($urandom_range(0, 59)), 0, 0, '0, 0);
      if ($urandom_range(0, 99) < 35) begin
         case ($urandom_range(0, 7))
            0: begin
               r.year_chars   = $urandom;
               r.month_chars  = 16'($urandom);
               r.day_chars    = 16'($urandom);
               r.hour_chars   = 16'($urandom);
               r.minute_chars = 16'($urandom);
               r.date_short   = 1'($urandom_range(0, 1));
               r.time_short   = 1'($urandom_range(0, 1));
            end
            1: r.year_chars = $urandom;
            2: r.month_chars = two_digits($urandom_range(0, 99));
            3: r.day_chars = two_digits($urandom_range(0, 99));
            4: begin
               r.hour_chars   = two_digits($urandom_range(0, 99));
               r.minute_chars = two_digits($urandom_range(0, 99));
            end
            5: begin
               r.date_short = 1'($urandom_range(0, 1));
               r.time_short = 1'($urandom_range(0, 1));
            end
            6: begin
               // bytes just around the digits: odd values that often pass the checks
               for (i = 0; i < 4; i++) r.year_chars[i*8 +: 8] = 8'($urandom_range(36, 70));
               for (i = 0; i < 2; i++) begin
                  r.month_chars[i*8 +: 8]  = 8'($urandom_range(40, 60));
                  r.day_chars[i*8 +: 8]    = 8'($urandom_range(40, 60));
                  r.hour_chars[i*8 +: 8]   = 8'($urandom_range(44, 60));
                  r.minute_chars[i*8 +: 8] = 8'($urandom_range(44, 60));
               end
            end
            default: begin
               r.month_chars = 16'($urandom);
               r.day_chars   = 16'($urandom);
            end
         endcase
      end
      return r;
   endfunction

   // Offer one stamp and hold it until accepted; called at a rising edge
   task automatic drive_stamp(input stamp_type s);
      dtem_pkg::req_type beat;
      logic [dtem_pkg::REQ_USER_W-1:0] flags;
      result_type e;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      beat.year_chars   = s.year_chars;
      beat.month_chars  = s.month_chars;
      beat.day_chars    = s.day_chars;
      beat.hour_chars   = s.hour_chars;
      beat.minute_chars = s.minute_chars;
      flags = '0;
      flags[dtem_pkg::USER_DATE_SHORT] = s.date_short;
      flags[dtem_pkg::USER_TIME_SHORT] = s.time_short;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= flags;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (s.known) begin
         e.minutes = s.want_minutes;
         e.valid   = s.want_valid;
      end else begin
         e = epoch_minutes_of(s);
      end
      e.beat = beats_sent;
      pending_epochs.push_back(e);
      beats_sent++;
   endtask

   task automatic check_result();
      result_type e;
      if (pending_epochs.size() == 0) begin
         flag_mismatch($sformatf("result with nothing expected: %h", rsp_tdata));
         return;
      end
      e = pending_epochs.pop_front();
      if (rsp_tdata[37:0] !== e.minutes)
         flag_mismatch($sformatf("beat %0d abs_minutes %0d, want %0d", e.beat,
                                 $signed(rsp_tdata[37:0]), $signed(e.minutes)));
      if (rsp_tuser[0] !== e.valid)
         flag_mismatch($sformatf("beat %0d time_valid %b, want %b", e.beat,
                                 rsp_tuser[0], e.valid));
      if (rsp_tdata[39:38] !== 2'b00)
         flag_mismatch($sformatf("beat %0d fill bits %b", e.beat, rsp_tdata[39:38]));
      beats_checked++;
   endtask

   // Receiver: checks each accepted beat, then picks rsp_tready for the next edge
   initial begin : receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) check_result();
         if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Sender and run control
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_directed();
      foreach (directed_stamps[i]) drive_stamp(directed_stamps[i]);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // long receiver hold-off twice, with the sender still pushing
         if (n == 400 || n == 1000) hold_request = 1;
         if (n == RANDOM_BEATS - CALM_BEATS) calm_tail = 1;
         stamp = random_stamp();
         drive_stamp(stamp);
      end
      req_tvalid <= 1'b0;

      drain_cycles = 0;
      while (pending_epochs.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_PAD) @(posedge clock);
      if (pending_epochs.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_epochs.size()));

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
